/* rtl/gps_pkg.sv */
// Shared constants, types and window table builder for the granular pitch shifter.
`timescale 1ns / 1ps
package gps_pkg;

  localparam int GRAIN_LEN  = 2048;
  localparam int OVERLAP    = 4;
  localparam int STORE_LEN  = GRAIN_LEN * OVERLAP;
  localparam int TAP_STEP   = GRAIN_LEN / OVERLAP;

  localparam int SAMP_W     = 16;
  localparam int RATIO_W    = 16;
  localparam int RATIO_FRAC = 12;
  localparam int WIN_W      = 16;
  localparam int WIN_FRAC   = 15;

  localparam int POS_W  = $clog2(STORE_LEN);
  localparam int WIN_AW = $clog2(GRAIN_LEN);
  localparam int OVL_SH = $clog2(OVERLAP);
  localparam int TCNT_W = (OVERLAP > 1) ? $clog2(OVERLAP) : 1;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_BYPASS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RATIO  = 1'd1;

  localparam logic [RATIO_W-1:0] RATIO_RESET = 16'd4096;

  localparam logic [63:0] Q30_ONE = 64'd1073741824;
  localparam logic [63:0] PI_Q30  = 64'd3373259426;

  typedef struct packed {
    logic               bypass_mode;
    logic [RATIO_W-1:0] rate_q12;
  } cfg_t;

  typedef logic [WIN_W-1:0] win_rom_t [GRAIN_LEN];

  // sin^2(pi*n/(GRAIN_LEN-1)) in Q15, Q30 sine series with truncating steps
  function automatic logic [WIN_W-1:0] hann_entry(input int unsigned n);
    logic [63:0] f;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] s;
    logic [63:0] w;
    f = (64'(n) << 32) / 64'(GRAIN_LEN - 1);
    if (f > 64'd2147483648) begin
      f = 64'd4294967296 - f;
    end
    x  = (f * PI_Q30) >> 32;
    x2 = (x * x) >> 30;
    t  = Q30_ONE - x2 / 64'd110;
    t  = Q30_ONE - ((x2 * t) >> 30) / 64'd72;
    t  = Q30_ONE - ((x2 * t) >> 30) / 64'd42;
    t  = Q30_ONE - ((x2 * t) >> 30) / 64'd20;
    t  = Q30_ONE - ((x2 * t) >> 30) / 64'd6;
    s  = (x * t) >> 30;
    w  = (s * s + (64'd1 << 44)) >> 45;
    if (w > 64'd32768) begin
      w = 64'd32768;
    end
    return w[WIN_W-1:0];
  endfunction

  function automatic win_rom_t build_win_rom();
    win_rom_t rom;
    for (int unsigned n = 0; n < GRAIN_LEN; n++) begin
      rom[n] = hann_entry(n);
    end
    return rom;
  endfunction

endpackage

/* rtl/gps_store.sv */
// Sample store: one write port, one registered read port.
`timescale 1ns / 1ps
module gps_store (
  input  logic                       clk,
  input  logic                       we,
  input  logic [gps_pkg::POS_W-1:0]  waddr,
  input  logic [gps_pkg::SAMP_W-1:0] wdata,
  input  logic [gps_pkg::POS_W-1:0]  raddr,
  output logic [gps_pkg::SAMP_W-1:0] rdata
);
  import gps_pkg::*;

  logic [SAMP_W-1:0] mem [STORE_LEN];
  logic [SAMP_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* rtl/gps_win_rom.sv */
// Hann window ROM, registered read.
`timescale 1ns / 1ps
module gps_win_rom (
  input  logic                       clk,
  input  logic [gps_pkg::WIN_AW-1:0] addr,
  output logic [gps_pkg::WIN_W-1:0]  data
);
  import gps_pkg::*;

  localparam win_rom_t WinRom = build_win_rom();

  logic [WIN_W-1:0] data_r;

  always_ff @(posedge clk) begin
    data_r <= WinRom[addr];
  end

  assign data = data_r;

endmodule

/* rtl/gps_core.sv */
// Sequencer and datapath: store write, tap reads, averaging, windowing, bypass, output register.
`timescale 1ns / 1ps
module gps_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  gps_pkg::cfg_t                     cfg,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [gps_pkg::SAMP_W-1:0] in_sample_in,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [gps_pkg::SAMP_W-1:0] out_sample_out
);
  import gps_pkg::*;

  localparam int OFF_W = POS_W + 1;
  localparam int TP_W  = OFF_W + RATIO_W + 1;
  localparam int SUM_W = SAMP_W + OVL_SH + 1;
  localparam int PR_W  = SAMP_W + WIN_W + 1;
  localparam int RES_W = PR_W - WIN_FRAC;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WRITE,
    ST_TAPS,
    ST_DRAIN,
    ST_AVG,
    ST_SCALE,
    ST_FINISH
  } state_t;

  state_t                    st_r;
  logic signed [SAMP_W-1:0]  samp_r;
  logic [POS_W-1:0]          wpos_r;
  logic                      wrapped_r;
  logic [TCNT_W-1:0]         tcnt_r;
  logic                      iss_r;
  logic                      hit_r;
  logic signed [SUM_W-1:0]   sum_r;
  logic signed [PR_W-1:0]    prod_r;
  logic signed [SAMP_W-1:0]  res_r;
  logic                      out_valid_r;
  logic signed [SAMP_W-1:0]  out_data_r;

  logic [SAMP_W-1:0]         rd_data;
  logic [WIN_W-1:0]          win;

  logic signed [OFF_W-1:0]   tap_d;
  logic signed [TP_W-1:0]    tap_p;
  logic [TP_W-1:0]           tap_mag;
  logic [POS_W-1:0]          tap_q;
  logic [POS_W-1:0]          tap_addr;
  logic                      tap_hit;

  logic signed [SUM_W-1:0]   rd_ext;
  logic signed [SUM_W-1:0]   sum_bias;
  logic signed [SUM_W-1:0]   avg_full;
  logic signed [SAMP_W-1:0]  avg;

  logic                      p_neg;
  logic [PR_W-1:0]           p_mag;
  logic [RES_W-1:0]          p_sh;
  logic signed [RES_W-1:0]   res_c;
  logic signed [SAMP_W-1:0]  res_sat;

  logic                      in_acc;
  logic                      out_take;

  gps_store u_store (
    .clk   (clk),
    .we    (st_r == ST_WRITE),
    .waddr (wpos_r),
    .wdata (samp_r),
    .raddr (tap_addr),
    .rdata (rd_data)
  );

  gps_win_rom u_win (
    .clk  (clk),
    .addr (wpos_r[WIN_AW-1:0]),
    .data (win)
  );

  assign in_stall       = (st_r != ST_IDLE);
  assign in_acc         = in_valid && !in_stall;
  assign out_take       = out_valid_r && !out_stall;
  assign out_valid      = out_valid_r;
  assign out_sample_out = out_data_r;

  // tap address: trunc0((wpos - g*step) * ratio / 4096) mod store length
  always_comb begin
    tap_d    = $signed({1'b0, wpos_r}) - $signed(OFF_W'(tcnt_r) * OFF_W'(TAP_STEP));
    tap_p    = tap_d * $signed({1'b0, cfg.rate_q12});
    tap_mag  = tap_p[TP_W-1] ? TP_W'(-tap_p) : TP_W'(tap_p);
    tap_q    = tap_mag[RATIO_FRAC +: POS_W];
    tap_addr = tap_p[TP_W-1] ? (POS_W'(0) - tap_q) : tap_q;
    // entries past the write point were never written until the first wrap
    tap_hit  = wrapped_r || (tap_addr <= wpos_r);
  end

  always_comb begin
    rd_ext   = SUM_W'($signed(rd_data));
    sum_bias = sum_r[SUM_W-1] ? SUM_W'(OVERLAP - 1) : '0;
    avg_full = (sum_r + sum_bias) >>> OVL_SH;
    avg      = avg_full[SAMP_W-1:0];
  end

  always_comb begin
    p_neg = prod_r[PR_W-1];
    p_mag = p_neg ? PR_W'(-prod_r) : PR_W'(prod_r);
    p_sh  = p_mag[WIN_FRAC +: RES_W];
    res_c = p_neg ? -$signed(p_sh) : $signed(p_sh);
    if (res_c > RES_W'(32767)) begin
      res_sat = 16'sh7FFF;
    end else if (res_c < -RES_W'(32768)) begin
      res_sat = -16'sh8000;
    end else begin
      res_sat = res_c[SAMP_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      wpos_r      <= '0;
      wrapped_r   <= 1'b0;
      iss_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // in ST_FINISH the output register is reloaded below
      if (out_take && st_r != ST_FINISH) begin
        out_valid_r <= 1'b0;
      end
      if (iss_r) begin
        sum_r <= sum_r + (hit_r ? rd_ext : '0);
      end
      unique case (st_r)
        ST_IDLE: begin
          if (in_acc) begin
            samp_r <= in_sample_in;
            if (cfg.bypass_mode) begin
              res_r <= in_sample_in;
              st_r  <= ST_FINISH;
            end else begin
              st_r <= ST_WRITE;
            end
          end
        end
        ST_WRITE: begin
          tcnt_r <= '0;
          sum_r  <= '0;
          iss_r  <= 1'b0;
          st_r   <= ST_TAPS;
        end
        ST_TAPS: begin
          iss_r  <= 1'b1;
          hit_r  <= tap_hit;
          tcnt_r <= tcnt_r + 1'b1;
          if (tcnt_r == TCNT_W'(OVERLAP - 1)) begin
            st_r <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          iss_r <= 1'b0;
          st_r  <= ST_AVG;
        end
        ST_AVG: begin
          prod_r <= avg * $signed({1'b0, win});
          st_r   <= ST_SCALE;
        end
        ST_SCALE: begin
          res_r <= res_sat;
          if (wpos_r == POS_W'(STORE_LEN - 1)) begin
            wpos_r    <= '0;
            wrapped_r <= 1'b1;
          end else begin
            wpos_r <= wpos_r + 1'b1;
          end
          st_r <= ST_FINISH;
        end
        ST_FINISH: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r <= 1'b1;
            out_data_r  <= res_r;
            st_r        <= ST_IDLE;
          end
        end
        default: begin
          st_r <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_wrap_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    wrapped_r |=> wrapped_r)
    else $error("fill mark cleared outside reset");

  a_wpos_step: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_SCALE && wpos_r != POS_W'(STORE_LEN - 1)) |=>
      wpos_r == $past(wpos_r) + 1'b1)
    else $error("write position did not advance by one");

  a_bypass_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && cfg.bypass_mode) |=> ($stable(wpos_r) && st_r == ST_FINISH))
    else $error("bypass word touched the write position");

  a_finish_wait: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_FINISH && out_valid_r && out_stall) |=> st_r == ST_FINISH)
    else $error("result dropped while output register full");

  a_tap_count: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_DRAIN) |-> (iss_r && tcnt_r == TCNT_W'(OVERLAP % (1 << TCNT_W))))
    else $error("tap sequence ended early");
`endif

endmodule

/* rtl/granular_pitch_shift_taps.sv */
// Top level of the granular pitch shifter: configuration registers and core.
//
// Usage:
//   Input channel in_valid / in_stall / in_sample_in carries one signed Q1.15
//   word; it is accepted on a rising edge with in_valid high and in_stall low.
//   Output channel out_valid / out_stall / out_sample_out returns one word per
//   accepted input, in order.
//   Config port: cfg_we writes cfg_data to register cfg_index (0 bypass_mode,
//   1 playback ratio Q4.12). Write only while the block is idle.
// Sequence:
//   Shifting: an accepted word passes the states write, taps, drain, average,
//   scale and finish; no new word is taken until the core is idle again.
//   The four tap reads go one per cycle through the store's single read port.
//   Bypass: the word skips to finish and the output register, then idle again.
// Reset (synchronous, rst_n low): bypass off, ratio 1.0, write position 0.
//   The store is not swept; a fill mark treats unwritten entries as zero.
// Back-pressure: a result waits in the output register while out_stall is
//   high; the next word is still accepted and processed, then holds in the
//   core until the output register frees.
`timescale 1ns / 1ps
module granular_pitch_shift_taps (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_we,
  input  logic [gps_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [gps_pkg::CFG_DATA_W-1:0]        cfg_data,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [gps_pkg::SAMP_W-1:0]     in_sample_in,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [gps_pkg::SAMP_W-1:0]     out_sample_out
);
  import gps_pkg::*;

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.bypass_mode <= 1'b0;
      cfg_r.rate_q12    <= RATIO_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_BYPASS: cfg_r.bypass_mode <= cfg_data[0];
        CFG_RATIO:  cfg_r.rate_q12    <= cfg_data[RATIO_W-1:0];
        default: begin
        end
      endcase
    end
  end

  gps_core u_core (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg_r),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_sample_in   (in_sample_in),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_sample_out (out_sample_out)
  );

endmodule

/* tb/sv/tb_granular_pitch_shift_taps.sv */
// Self-checking testbench for granular_pitch_shift_taps with its own shadow model of the shifter.
`timescale 1ns / 1ps
module tb_granular_pitch_shift_taps;
  import gps_pkg::*;

  localparam int CHUNK_ITEMS   = 185;
  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 12;
  localparam longint unsigned ONE_Q30   = 64'd1073741824;
  localparam longint unsigned PI_AS_Q30 = 64'd3373259426;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [SAMP_W-1:0] in_sample_in = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [SAMP_W-1:0] out_sample_out;

  // shadow state of the shifter
  logic signed [SAMP_W-1:0] shadow_store [STORE_LEN];
  int hann_tab [GRAIN_LEN];
  int unsigned wr_pos = 0;
  logic bypass_reg = 1'b0;
  logic [15:0] ratio_reg = 16'd4096;

  logic signed [SAMP_W-1:0] pending_samples [$];
  logic signed [SAMP_W-1:0] predicted_out [$];
  int err_cnt = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_ticket = 0;
  int hold_seen = 0;
  int hold_left = 0;

  granular_pitch_shift_taps u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_sample_in   (in_sample_in),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_sample_out (out_sample_out)
  );

  always #1 clk = ~clk;

  // sin^2 window in Q15: Q30 sine series evaluated Horner style, truncating
  function automatic int window_q15(input int unsigned n);
    longint unsigned nn, frac, ang, ang2, poly, sn, w;
    int divs [5];
    divs = '{110, 72, 42, 20, 6};
    nn = n;
    frac = (nn << 32) / longint'(GRAIN_LEN - 1);
    if (frac > 64'd2147483648) begin
      frac = 64'd4294967296 - frac;
    end
    ang  = (frac * PI_AS_Q30) >> 32;
    ang2 = (ang * ang) >> 30;
    poly = ONE_Q30;
    for (int k = 0; k < 5; k++) begin
      poly = ONE_Q30 - ((ang2 * poly) >> 30) / longint'(divs[k]);
    end
    sn = (ang * poly) >> 30;
    w  = (sn * sn + (64'd1 << 44)) >> 45;
    if (w > 64'd32768) begin
      w = 64'd32768;
    end
    return int'(w);
  endfunction

  // one input word through the shadow shifter, returns the expected output word
  function automatic logic signed [SAMP_W-1:0] shift_sample(input logic signed [SAMP_W-1:0] smp);
    longint d, prod, q, r, sum, avg, res;
    if (bypass_reg) begin
      return smp;
    end
    shadow_store[wr_pos] = smp;
    sum = 0;
    for (int g = 0; g < OVERLAP; g++) begin
      d = longint'(wr_pos) - longint'(g * TAP_STEP);
      prod = d * longint'(ratio_reg);
      if (prod < 0) begin
        q = -((-prod) >>> 12);
      end else begin
        q = prod >>> 12;
      end
      // true modulo: negative tap offsets wrap to the top of the store
      r = q % longint'(STORE_LEN);
      if (r < 0) begin
        r = r + longint'(STORE_LEN);
      end
      sum = sum + longint'(shadow_store[r]);
    end
    avg = sum / longint'(OVERLAP);
    prod = avg * longint'(hann_tab[wr_pos % GRAIN_LEN]);
    if (prod < 0) begin
      res = -((-prod) >>> 15);
    end else begin
      res = prod >>> 15;
    end
    if (res > 32767) begin
      res = 32767;
    end
    if (res < -32768) begin
      res = -32768;
    end
    wr_pos = (wr_pos + 1) % STORE_LEN;
    return res[15:0];
  endfunction

  function automatic logic [15:0] pick_sample();
    logic [15:0] corners [4];
    corners = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF};
    case ($urandom_range(9))
      0: return corners[$urandom_range(3)];
      1: return 16'($signed($urandom_range(31)) - 16);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_BYPASS) begin
      bypass_reg = val[0];
    end else begin
      ratio_reg = val;
    end
  endtask

  task automatic set_mode(input logic byp, input logic [15:0] ratio);
    // upper data bits are junk on purpose; only bit 0 matters for bypass
    write_reg(CFG_BYPASS, {15'($urandom), byp});
    write_reg(CFG_RATIO, ratio);
  endtask

  task automatic wait_idle();
    while (pending_samples.size() != 0 || in_valid || predicted_out.size() != 0) begin
      @(negedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic push_random(input int count);
    for (int i = 0; i < count; i++) begin
      pending_samples.push_back(pick_sample());
    end
  endtask

  // driver: predict on accept, then offer the next word or idle
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        predicted_out.push_back(shift_sample(in_sample_in));
      end
      if (!in_valid || !in_stall) begin
        if (pending_samples.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_sample_in <= pending_samples.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver back-pressure, with one long hold-off requested by the stimulus
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_ticket != hold_seen) begin
      hold_seen <= hold_ticket;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    logic signed [SAMP_W-1:0] want;
    if (rst_n && out_valid && !out_stall) begin
      if (predicted_out.size() == 0) begin
        $display("%0t: unexpected output word, expected none, got %0d", $time, out_sample_out);
        err_cnt++;
      end else begin
        want = predicted_out.pop_front();
        if (out_sample_out !== want) begin
          $display("%0t: sample_out mismatch, expected %0d, got %0d",
                   $time, want, out_sample_out);
          err_cnt++;
        end
      end
    end
  end

  initial begin
    #1_000_000;
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    logic byp;
    logic [15:0] ratio;
    for (int i = 0; i < STORE_LEN; i++) begin
      shadow_store[i] = '0;
    end
    for (int unsigned n = 0; n < GRAIN_LEN; n++) begin
      hann_tab[n] = window_q15(n);
    end
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings; early positions give negative tap offsets
    pending_samples = '{16'sh7FFF, 16'sh8000, 16'sh0000, 16'shFFFF, 16'sh0001,
                        16'sh5555, 16'shAAAA};
    wait_idle();
    set_mode(1'b0, 16'd0);          // zero ratio: all taps on address 0
    pending_samples = '{16'sh7FFF, 16'sh8000, 16'sh3039};
    wait_idle();
    set_mode(1'b0, 16'hFFFF);
    pending_samples = '{16'sh7FFF, 16'sh8000, 16'sh1234};
    wait_idle();
    set_mode(1'b1, 16'hFFFF);
    pending_samples = '{16'sh8000, 16'sh7FFF, 16'sh0000, 16'shFFFF};
    wait_idle();
    set_mode(1'b0, 16'd1);
    pending_samples = '{16'sh4000, 16'shC000};
    wait_idle();

    for (int c = 0; c < 6; c++) begin
      send_idle_pct <= (c < 2) ? 29 : (c < 4) ? 61 : 0;
      recv_idle_pct <= (c < 2) ? 61 : (c < 4) ? 29 : 0;
      byp = (c == 3);
      case (c)
        0: ratio = 16'd4096;
        1: ratio = 16'hFFFF;
        4: ratio = 16'($urandom_range(12288, 2048));
        5: ratio = 16'($urandom_range(4096, 1));
        default: ratio = 16'($urandom);
      endcase
      set_mode(byp, ratio);
      if (c == 4) begin
        push_random(CHUNK_ITEMS);
        @(posedge clk);
        hold_ticket <= hold_ticket + 1;
      end else if (c == 5) begin
        push_random(CHUNK_ITEMS / 2);
        wait_idle();
        push_random(CHUNK_ITEMS - CHUNK_ITEMS / 2);
      end else begin
        push_random(CHUNK_ITEMS);
      end
      wait_idle();
    end

    repeat (20) @(posedge clk);
    if (err_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
